@@ src/cdft_pkg.sv @@
// ----------------------------------------------------------------------------
// cdft_pkg
// Shared types, constants and the twiddle generator of the direct DFT engine.
// ----------------------------------------------------------------------------
package cdft_pkg;

    localparam int POINTS_DEFAULT = 16;
    localparam int IDX_MAX_W      = 6;
    localparam int SAMPLE_W       = 16;
    localparam int TWIDDLE_W      = 16;
    localparam int BIN_W          = 23;
    localparam int TERM_W         = 18;
    localparam int S_DATA_W       = 32;
    localparam int M_DATA_W       = 56;
    localparam int CORDIC_STEPS   = 16;

    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint CORDIC_ATAN [CORDIC_STEPS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    localparam logic signed [31:0] BIN_MAX = 32'sd4194303;
    localparam logic signed [31:0] BIN_MIN = -32'sd4194304;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } cdft_state_t;

    // Controller to datapath
    typedef struct packed {
        logic                 load_we;
        logic                 issue;
        logic                 first;
        logic                 last;
        logic                 emit;
        logic                 emit_last;
        logic [IDX_MAX_W-1:0] addr;
        logic [IDX_MAX_W-1:0] phase;
        logic [IDX_MAX_W-1:0] bin;
    } cdft_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic acc_done;
        logic out_free;
    } cdft_status_t;

    // Round a Q30 value to Q15 with saturation.
    function automatic logic [TWIDDLE_W-1:0] to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd32767) begin
            r = 64'sd32767;
        end
        if (r < -64'sd32768) begin
            r = -64'sd32768;
        end
        return r[TWIDDLE_W-1:0];
    endfunction

    // Twiddle for a 24-bit binary angle; returns {sin, cos} in Q1.15.
    // Only evaluated at elaboration to build the constant table.
    function automatic logic [2*TWIDDLE_W-1:0] tw_cordic(input logic [23:0] ang);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        logic [TWIDDLE_W-1:0] c;
        logic [TWIDDLE_W-1:0] s;
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = longint'({42'd0, ang[21:0]});
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - CORDIC_ATAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + CORDIC_ATAN[i];
            end
        end
        case (ang[23:22])
            2'd0: begin
                c = to_q15(x);
                s = to_q15(y);
            end
            2'd1: begin
                c = to_q15(-y);
                s = to_q15(x);
            end
            2'd2: begin
                c = to_q15(-x);
                s = to_q15(-y);
            end
            default: begin
                c = to_q15(y);
                s = to_q15(-x);
            end
        endcase
        return {s, c};
    endfunction

endpackage

@@ src/complex_dft_engine.sv @@
// ----------------------------------------------------------------------------
// complex_dft_engine
// Direct DFT of POINTS complex 16-bit samples with one shared complex MAC.
// ----------------------------------------------------------------------------
// Usage: stream in POINTS samples (real in the low half of s_tdata, imaginary
// in the high half); once the last one is taken, the engine stops accepting
// input and computes X[0] .. X[POINTS-1] in order, one complex multiply-
// accumulate per cycle. Each bin takes POINTS multiply-accumulates; then
// the pipeline drains and the bin is handed off before the next bin starts.
// The single MAC pipeline does the store read and twiddle lookup, four
// 16x16 products, then round and accumulate. Bins leave through an output
// register; m_tlast marks bin POINTS-1. Twiddles are a constant Q1.15 table
// built at elaboration; products are rounded by a 15-bit shift and only the
// final sums saturate to 23 bits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module complex_dft_engine #(
    parameter int POINTS = cdft_pkg::POINTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: sample_real [15:0], sample_imag [31:16]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cdft_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: bin_real [22:0], bin_imag [45:23], bin_index [51:46], zero fill
    // m_tlast: last_bin
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdft_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cdft_pkg::*;

    // Command and status between sequencer and datapath
    cdft_cmd_t    cmd;
    cdft_status_t status;

    // Sequencer: sample load, term and bin counters, result hand-off
    cdft_ctrl #(
        .POINTS (POINTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: store, twiddles, MAC pipeline, output register
    cdft_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/cdft_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdft_ctrl
// Sequencer: loads the sample block, walks terms and bins, hands off results.
// ----------------------------------------------------------------------------
module cdft_ctrl #(
    parameter int POINTS = cdft_pkg::POINTS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  cdft_pkg::cdft_status_t status,
    output cdft_pkg::cdft_cmd_t    cmd
);
    import cdft_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POINTS - 1);
    localparam logic [IDX_W:0]   PH_WRAP  = (IDX_W + 1)'(POINTS);

    cdft_state_t state_reg, state_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] phase_reg, phase_next;
    logic [IDX_W:0]   phase_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            k_reg     <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid && n_reg == IDX_LAST) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (n_reg == IDX_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.acc_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = (k_reg == IDX_LAST) ? ST_LOAD : ST_MAC;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Counters
    always_comb begin
        n_next     = n_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        phase_sum  = {1'b0, phase_reg} + {1'b0, k_reg};
        if (phase_sum >= PH_WRAP) begin
            phase_sum = phase_sum - PH_WRAP;
        end
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    n_next = (n_reg == IDX_LAST) ? '0 : n_reg + 1'b1;
                    k_next = '0;
                    phase_next = '0;
                end
            end
            ST_MAC: begin
                if (n_reg == IDX_LAST) begin
                    n_next     = '0;
                    phase_next = '0;
                end else begin
                    n_next     = n_reg + 1'b1;
                    phase_next = phase_sum[IDX_W-1:0];
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    k_next = (k_reg == IDX_LAST) ? '0 : k_reg + 1'b1;
                end
            end
            default: begin
                n_next = n_reg;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd           = '0;
        s_tready      = 1'b0;
        cmd.addr      = IDX_MAX_W'(n_reg);
        cmd.phase     = IDX_MAX_W'(phase_reg);
        cmd.bin       = IDX_MAX_W'(k_reg);
        cmd.first     = (n_reg == '0);
        cmd.last      = (n_reg == IDX_LAST);
        cmd.emit_last = (k_reg == IDX_LAST);
        case (state_reg)
            ST_LOAD: begin
                s_tready    = 1'b1;
                cmd.load_we = s_tvalid;
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ src/cdft_datapath.sv @@
// ----------------------------------------------------------------------------
// cdft_datapath
// Sample store, twiddle table, complex MAC pipeline and output register.
// ----------------------------------------------------------------------------
module cdft_datapath #(
    parameter int POINTS = cdft_pkg::POINTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [cdft_pkg::S_DATA_W-1:0] s_tdata,
    input  cdft_pkg::cdft_cmd_t           cmd,
    output cdft_pkg::cdft_status_t        status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cdft_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cdft_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam int ACC_W = TERM_W + IDX_W;

    // Constant twiddle table, one entry per phase
    logic [2*TWIDDLE_W-1:0] tw_tab [POINTS];
    for (genvar p = 0; p < POINTS; p++) begin : g_tw
        localparam longint ANG_FULL = ((longint'(p) <<< 24) + POINTS / 2) / POINTS;
        localparam logic [23:0] ANG = ANG_FULL[23:0];
        assign tw_tab[p] = tw_cordic(ANG);
    end

    logic [2*SAMPLE_W-1:0] store_mem [POINTS];

    // Stage 1: operand fetch
    logic                   v1_reg, first1_reg, last1_reg;
    logic [2*SAMPLE_W-1:0]  smp_reg;
    logic [2*TWIDDLE_W-1:0] tw_reg;
    // Stage 2: products
    logic                   v2_reg, first2_reg, last2_reg;
    logic signed [31:0]     p_ac_reg, p_bs_reg, p_bc_reg, p_as_reg;
    // Stage 3: accumulate
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_im_reg;
    logic                    acc_done_reg;
    // Output register
    logic                    out_valid_reg;
    logic [BIN_W-1:0]        out_re_reg, out_im_reg;
    logic [IDX_MAX_W-1:0]    out_bin_reg;
    logic                    out_last_reg;

    logic signed [SAMPLE_W-1:0]  sa, sb;
    logic signed [TWIDDLE_W-1:0] tc, ts;
    logic signed [TERM_W-1:0]    term_re, term_im;
    logic signed [31:0]          acc_ext_re, acc_ext_im;

    function automatic logic signed [16:0] rnd15(input logic signed [31:0] v);
        logic signed [32:0] t;
        t = 33'(v) + 33'sd16384;
        return $signed(t[31:15]);
    endfunction

    function automatic logic [BIN_W-1:0] sat_bin(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > BIN_MAX) begin
            r = BIN_MAX;
        end else if (v < BIN_MIN) begin
            r = BIN_MIN;
        end
        return r[BIN_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            store_mem[cmd.addr[IDX_W-1:0]] <= s_tdata[2*SAMPLE_W-1:0];
        end
        smp_reg <= store_mem[cmd.addr[IDX_W-1:0]];
    end

    assign sa = $signed(smp_reg[SAMPLE_W-1:0]);
    assign sb = $signed(smp_reg[2*SAMPLE_W-1:SAMPLE_W]);
    assign tc = $signed(tw_reg[TWIDDLE_W-1:0]);
    assign ts = $signed(tw_reg[2*TWIDDLE_W-1:TWIDDLE_W]);

    assign term_re = TERM_W'(rnd15(p_ac_reg)) + TERM_W'(rnd15(p_bs_reg));
    assign term_im = TERM_W'(rnd15(p_bc_reg)) - TERM_W'(rnd15(p_as_reg));

    assign acc_ext_re = 32'(acc_reg);
    assign acc_ext_im = 32'(acc_im_reg);

    always_ff @(posedge aclk) begin
        tw_reg   <= tw_tab[cmd.phase[IDX_W-1:0]];
        p_ac_reg <= sa * tc;
        p_bs_reg <= sb * ts;
        p_bc_reg <= sb * tc;
        p_as_reg <= sa * ts;
        if (v2_reg) begin
            if (first2_reg) begin
                acc_reg    <= ACC_W'(term_re);
                acc_im_reg <= ACC_W'(term_im);
            end else begin
                acc_reg    <= acc_reg + ACC_W'(term_re);
                acc_im_reg <= acc_im_reg + ACC_W'(term_im);
            end
        end
        if (cmd.emit) begin
            out_re_reg   <= sat_bin(acc_ext_re);
            out_im_reg   <= sat_bin(acc_ext_im);
            out_bin_reg  <= cmd.bin;
            out_last_reg <= cmd.emit_last;
        end
        first1_reg <= cmd.first;
        last1_reg  <= cmd.last;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            acc_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg       <= cmd.issue;
            v2_reg       <= v1_reg;
            acc_done_reg <= v2_reg && last2_reg;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.acc_done = acc_done_reg;
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W - 2*BIN_W - IDX_MAX_W){1'b0}},
                       out_bin_reg, out_im_reg, out_re_reg};

endmodule
